>>> design/fac_pkg.sv
// fac_pkg: shared types for the trial-division prime factorizer.
// No dependencies; compiled first.
`timescale 1ns / 1ps

package fac_pkg;

    // Sequencer states of the factorizer.
    typedef enum logic [1:0] {
        ST_IDLE,    // waiting for a number
        ST_DIV,     // restoring divider running, one quotient bit a cycle
        ST_DECIDE   // quotient and remainder ready: emit, step divisor or finish
    } state_t;

endpackage

>>> design/fac_if.sv
// Stream interfaces for the factorizer: number in, factors out.
// Valid/ready handshake; depends on nothing.
`timescale 1ns / 1ps

interface fac_in_if #(parameter int VALUE_BITS = 31);
    logic                  valid;
    logic                  ready;
    logic [VALUE_BITS-1:0] value;

    modport source (output valid, output value, input ready);
    modport sink   (input valid, input value, output ready);
endinterface

interface fac_out_if #(parameter int VALUE_BITS = 31);
    logic                  valid;
    logic                  ready;
    logic [VALUE_BITS-1:0] factor;
    logic                  last;

    modport source (output valid, output factor, output last, input ready);
    modport sink   (input valid, input factor, input last, output ready);
endinterface

>>> design/prime_factorizer.sv
// prime_factorizer: trial-division prime factorization over one shared divider.
// Depends on fac_pkg (states) and fac_in_if / fac_out_if (channels).
`timescale 1ns / 1ps
//
//  Channel   Interface    Dir   Payload               Notes
//  in_ch     fac_in_if    in    value[VALUE_BITS]     number to factor
//  out_ch    fac_out_if   out   factor, last          prime factors, ascending, with repeats
//
//  Each trial divisor runs the restoring divider (one quotient bit per cycle)
//  and then the decide state; a prime near 2^31 needs about 46340 trials.
//  Values below two are taken in one transfer and produce nothing.
//  in_ch.ready is high only while idle. A factor waiting in the output
//  register stalls the sequencer in the decide cycle only when the next
//  factor is due; the final factor is held while a new number is taken.
//  rst_n is asynchronous, active low, and clears the sequencer and out_ch.valid.

module prime_factorizer #(
    parameter int VALUE_BITS = 31
) (
    input  logic       clk,
    input  logic       rst_n,
    fac_in_if.sink     in_ch,
    fac_out_if.source  out_ch
);

    localparam int CNT_W = $clog2(VALUE_BITS);
    localparam logic [VALUE_BITS-1:0] ONE = VALUE_BITS'(1);
    localparam logic [VALUE_BITS-1:0] TWO = VALUE_BITS'(2);
    localparam logic [CNT_W-1:0] CNT_START = CNT_W'(VALUE_BITS - 1);

    fac_pkg::state_t state_reg, state_next;

    // rem: number still to factor; d: trial divisor.
    // quo/part: divider shift register (dividend shifts out, quotient in) and
    // partial remainder.
    logic [VALUE_BITS-1:0] rem_reg,  rem_next;
    logic [VALUE_BITS-1:0] d_reg,    d_next;
    logic [VALUE_BITS-1:0] quo_reg,  quo_next;
    logic [VALUE_BITS-1:0] part_reg, part_next;
    logic [CNT_W-1:0]      cnt_reg,  cnt_next;

    logic                  out_valid_reg, out_valid_next;
    logic [VALUE_BITS-1:0] factor_reg,    factor_next;
    logic                  last_reg,      last_next;

    // Shared divider step
    logic [VALUE_BITS:0]   div_shift;
    logic [VALUE_BITS:0]   div_diff;
    logic                  div_ge;

    // Decide cycle terms
    logic in_xfer;
    logic out_free;
    logic dec_final;   // d > rem / d: remaining rem is prime
    logic dec_hit;     // d divides rem

    assign in_xfer   = in_ch.valid && in_ch.ready;
    assign out_free  = !out_valid_reg || out_ch.ready;
    assign dec_final = d_reg > quo_reg;
    assign dec_hit   = part_reg == '0;

    // part < d keeps the shifted value below 2d, so the borrow bit is the compare
    assign div_shift = {part_reg, quo_reg[VALUE_BITS-1]};
    assign div_diff  = div_shift - {1'b0, d_reg};
    assign div_ge    = !div_diff[VALUE_BITS];

    assign in_ch.ready   = state_reg == fac_pkg::ST_IDLE;
    assign out_ch.valid  = out_valid_reg;
    assign out_ch.factor = factor_reg;
    assign out_ch.last   = last_reg;

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            fac_pkg::ST_IDLE:
            begin
                if (in_xfer && in_ch.value >= TWO)
                    state_next = fac_pkg::ST_DIV;
            end
            fac_pkg::ST_DIV:
            begin
                if (cnt_reg == '0)
                    state_next = fac_pkg::ST_DECIDE;
            end
            fac_pkg::ST_DECIDE:
            begin
                if (dec_final)
                begin
                    if (out_free)
                        state_next = fac_pkg::ST_IDLE;
                end
                else if (dec_hit)
                begin
                    if (out_free)
                        state_next = (quo_reg == ONE) ? fac_pkg::ST_IDLE : fac_pkg::ST_DIV;
                end
                else
                begin
                    state_next = fac_pkg::ST_DIV;
                end
            end
            default: state_next = fac_pkg::ST_IDLE;
        endcase
    end

    // Datapath and output register
    always_comb
    begin
        rem_next       = rem_reg;
        d_next         = d_reg;
        quo_next       = quo_reg;
        part_next      = part_reg;
        cnt_next       = cnt_reg;
        out_valid_next = out_valid_reg && !out_ch.ready;
        factor_next    = factor_reg;
        last_next      = last_reg;
        case (state_reg)
            fac_pkg::ST_IDLE:
            begin
                if (in_xfer)
                begin
                    rem_next  = in_ch.value;
                    d_next    = TWO;
                    quo_next  = in_ch.value;
                    part_next = '0;
                    cnt_next  = CNT_START;
                end
            end
            fac_pkg::ST_DIV:
            begin
                part_next = div_ge ? div_diff[VALUE_BITS-1:0] : div_shift[VALUE_BITS-1:0];
                quo_next  = {quo_reg[VALUE_BITS-2:0], div_ge};
                cnt_next  = cnt_reg - CNT_W'(1);
            end
            fac_pkg::ST_DECIDE:
            begin
                if (dec_final)
                begin
                    if (out_free)
                    begin
                        out_valid_next = 1'b1;
                        factor_next    = rem_reg;
                        last_next      = 1'b1;
                    end
                end
                else if (dec_hit)
                begin
                    if (out_free)
                    begin
                        // Factor found; a quotient of one means nothing is left.
                        out_valid_next = 1'b1;
                        factor_next    = d_reg;
                        last_next      = quo_reg == ONE;
                        rem_next       = quo_reg;
                        part_next      = '0;
                        cnt_next       = CNT_START;
                    end
                end
                else
                begin
                    d_next    = d_reg + ONE;
                    quo_next  = rem_reg;
                    part_next = '0;
                    cnt_next  = CNT_START;
                end
            end
            default:
            begin
                out_valid_next = out_valid_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= fac_pkg::ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg    <= rem_next;
        d_reg      <= d_next;
        quo_reg    <= quo_next;
        part_reg   <= part_next;
        cnt_reg    <= cnt_next;
        factor_reg <= factor_next;
        last_reg   <= last_next;
    end

`ifndef NO_ASSERTIONS
    // Trial divisor never drops below two while dividing.
    a_div_d_min: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == fac_pkg::ST_DIV |-> d_reg >= TWO)
        else $error("trial divisor below two during division");

    // Number under division is always above one.
    a_div_rem_min: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == fac_pkg::ST_DIV |-> rem_reg > ONE)
        else $error("remainder not above one during division");

    // Restoring divider keeps its partial remainder below the divisor.
    a_part_bound: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == fac_pkg::ST_DIV |-> part_reg < d_reg)
        else $error("partial remainder reached divisor");

    // A miss advances the divisor by one and restarts the divider.
    a_miss_step: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == fac_pkg::ST_DECIDE && !dec_final && !dec_hit)
        |=> (d_reg == $past(d_reg) + ONE && state_reg == fac_pkg::ST_DIV))
        else $error("divisor not stepped after a miss");
`endif

endmodule

>>> tb/prime_factor_checker.sv
// prime_factor_checker: watches both channels of the factorizer, predicts the factor
// stream of every accepted number and compares it with what comes out.
// Depends on nothing but the channel signals handed in by the testbench top.
`timescale 1ns / 1ps

module prime_factor_checker #(
    parameter int VALUE_BITS = 31
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    input  logic                  in_ready,
    input  logic [VALUE_BITS-1:0] in_value,
    input  logic                  out_valid,
    input  logic                  out_ready,
    input  logic [VALUE_BITS-1:0] out_factor,
    input  logic                  out_last,
    output int                    mismatches,
    output int                    outstanding
);

    typedef struct packed {
        logic [VALUE_BITS-1:0] factor;
        logic                  last;
    } factor_t;

    factor_t expected_factors[$];
    int      error_cnt   = 0;
    int      pending_cnt = 0;

    assign mismatches  = error_cnt;
    assign outstanding = pending_cnt;

    task automatic report_mismatch(input string what);
        $display("%0t ns: mismatch: %s", $time, what);
        error_cnt++;
    endtask

    // Trial division from 2 upward; the smallest divisor of the remainder is
    // always prime, so no separate primality test is needed. Each factor is
    // held back one step so the final one can carry the last flag.
    function automatic void queue_factors(input logic [VALUE_BITS-1:0] n);
        longint unsigned rem;
        longint unsigned d;
        factor_t         held;
        bit              have_held;
        rem       = n;
        d         = 2;
        have_held = 1'b0;
        held      = '0;
        while (rem > 1 && d <= rem / d)
        begin
            if (rem % d == 0)
            begin
                if (have_held)
                    expected_factors.push_back(held);
                held.factor = d[VALUE_BITS-1:0];
                held.last   = 1'b0;
                have_held   = 1'b1;
                rem         = rem / d;
            end
            else
            begin
                d++;
            end
        end
        // leftover above one is the largest prime factor
        if (rem > 1)
        begin
            if (have_held)
                expected_factors.push_back(held);
            held.factor = rem[VALUE_BITS-1:0];
            held.last   = 1'b0;
            have_held   = 1'b1;
        end
        if (have_held)
        begin
            held.last = 1'b1;
            expected_factors.push_back(held);
        end
    endfunction

    always @(posedge clk)
    begin
        factor_t want;
        if (rst_n)
        begin
            if (out_valid && out_ready)
            begin
                if (expected_factors.size() == 0)
                begin
                    report_mismatch($sformatf("factor %0d with nothing expected", out_factor));
                end
                else
                begin
                    want = expected_factors.pop_front();
                    if (out_factor !== want.factor)
                        report_mismatch($sformatf("factor %0d, expected %0d",
                                                  out_factor, want.factor));
                    if (out_last !== want.last)
                        report_mismatch($sformatf("last %b on factor %0d, expected %b",
                                                  out_last, out_factor, want.last));
                end
            end
            if (in_valid && in_ready)
                queue_factors(in_value);
            pending_cnt = expected_factors.size();
        end
    end

endmodule

>>> tb/prime_factorizer_tb.sv
// prime_factorizer_tb: drives numbers into the factorizer and throttles its output;
// prediction and comparison live in prime_factor_checker.
// Depends on fac_pkg, fac_in_if / fac_out_if and prime_factorizer from the design.
`timescale 1ns / 1ps

module prime_factorizer_tb;

    localparam int VALUE_BITS = 31;

    // Each trial divisor costs a full division inside the block, so a
    // random number is only kept if it factors within this many trials.
    localparam int TRIAL_BUDGET = 200;

    // Random numbers of two or more; 0 and 1 are sent too but not counted.
    localparam int RANDOM_ITEMS = 85;

    // Receiver hold-off for the back-pressure stretch, in cycles.
    localparam int LONG_HOLD_CYCLES = 2000;

    // Settle time after the last expected factor, in cycles.
    localparam int DRAIN_CYCLES = 200;

    // Bound on the whole run: the slowest directed number is the large prime,
    // and each random number is held to the trial budget, plus output stalls.
    localparam longint CYCLE_LIMIT = 4000000;

    logic   clk;
    logic   rst_n;
    int     send_idle_pct;
    int     recv_idle_pct;
    int     hold_cycles;
    int     mismatches;
    int     outstanding;
    longint cycle_cnt;

    // Directed numbers: below two, smallest primes, prime squares, a mid-size
    // and a large prime, the longest factor lists, and the top bit set.
    logic [VALUE_BITS-1:0] directed_values [15] = '{
        31'd0,           // no factors
        31'd1,           // no factors
        31'd2,           // smallest prime
        31'd3,
        31'd4,           // repeated factor
        31'd12,
        31'd49,          // prime square
        31'd961,         // 31 * 31
        31'd131042,      // 2 * 65521: cofactor far above the square root
        31'd65521,       // largest 16-bit prime
        31'd1000003,     // prime, about a thousand trials
        31'd1073741824,  // 2^30: thirty factors of two
        31'd1610612736,  // 3 * 2^29: thirty factors, last one differs
        31'd2147483646,  // all bits but bit 0 set: 2 * 3^2 * 7 * 11 * 31 * 151 * 331
        31'd1073741825   // top and bottom bit set: 5^2 * 13 * 41 * 61 * 1321
    };

    fac_in_if  #(.VALUE_BITS(VALUE_BITS)) in_ch ();
    fac_out_if #(.VALUE_BITS(VALUE_BITS)) out_ch ();

    prime_factorizer #(
        .VALUE_BITS (VALUE_BITS)
    ) dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_ch),
        .out_ch (out_ch)
    );

    prime_factor_checker #(
        .VALUE_BITS (VALUE_BITS)
    ) factor_chk (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_ch.valid),
        .in_ready    (in_ch.ready),
        .in_value    (in_ch.value),
        .out_valid   (out_ch.valid),
        .out_ready   (out_ch.ready),
        .out_factor  (out_ch.factor),
        .out_last    (out_ch.last),
        .mismatches  (mismatches),
        .outstanding (outstanding)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Watchdog: a hung handshake or a lost factor ends the run here.
    initial
    begin
        cycle_cnt = 0;
        forever
        begin
            @(posedge clk);
            cycle_cnt++;
            if (cycle_cnt > CYCLE_LIMIT)
            begin
                $display("FAIL");
                $finish;
            end
        end
    end

    // Number of trial divisions the block needs for v, stopping early once
    // the budget is passed. Only used to keep the random numbers cheap.
    function automatic int trial_count(input logic [VALUE_BITS-1:0] v, input int budget);
        longint unsigned rem;
        longint unsigned d;
        int              trials;
        rem    = v;
        d      = 2;
        trials = 0;
        while (rem > 1 && d <= rem / d && trials <= budget)
        begin
            if (rem % d == 0)
                rem = rem / d;
            else
                d++;
            trials++;
        end
        return trials;
    endfunction

    // Random number: mostly short widths, about a third full width. Every pick
    // is redrawn until it factors within the budget, which leaves smooth numbers
    // with long factor lists and a prime cofactor now and then.
    function automatic logic [VALUE_BITS-1:0] pick_value();
        logic [31:0]           mask;
        logic [VALUE_BITS-1:0] v;
        int                    width;
        do
        begin
            width = ($urandom_range(9) < 3) ? VALUE_BITS : $urandom_range(20, 2);
            mask  = (32'd1 << width) - 32'd1;
            v     = VALUE_BITS'($urandom & mask);
        end
        while (trial_count(v, TRIAL_BUDGET) > TRIAL_BUDGET);
        return v;
    endfunction

    // One transfer on in_ch. Called at a falling edge and returns at a falling
    // edge; valid is only dropped when an idle cycle is actually inserted, so
    // back-to-back numbers keep valid high with a single assignment per step.
    task automatic send_value(input logic [VALUE_BITS-1:0] v);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_ch.valid <= 1'b0;
            @(negedge clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.value <= v;
        @(posedge clk);
        while (!in_ch.ready)
            @(posedge clk);
        @(negedge clk);
    endtask

    // Receiver: random stalls, or a long hold-off when one is requested.
    // The hold-off is counted down here, so the sender keeps offering numbers
    // while the block's output register fills and in_ch.ready stays low.
    initial
    begin
        out_ch.ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (hold_cycles > 0)
            begin
                out_ch.ready <= 1'b0;
                hold_cycles--;
            end
            else
            begin
                out_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
            end
        end
    end

    initial
    begin
        int                    sent;
        int                    phase;
        logic [VALUE_BITS-1:0] v;

        rst_n         = 1'b0;
        in_ch.valid   = 1'b0;
        in_ch.value   = '0;
        send_idle_pct = 14;
        recv_idle_pct = 72;
        hold_cycles   = 0;
        sent          = 0;
        phase         = 0;

        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed numbers, under light sender idling and a slow receiver.
        foreach (directed_values[i])
            send_value(directed_values[i]);

        // Random numbers in three phases of idling: slow receiver, then slow
        // sender, then both at full rate. The full-rate phase opens with the
        // long receiver hold-off.
        while (sent < RANDOM_ITEMS)
        begin
            if (sent * 3 / RANDOM_ITEMS > phase)
            begin
                phase = sent * 3 / RANDOM_ITEMS;
                if (phase == 1)
                begin
                    send_idle_pct = 72;
                    recv_idle_pct = 14;
                end
                else
                begin
                    send_idle_pct = 0;
                    recv_idle_pct = 0;
                    hold_cycles   = LONG_HOLD_CYCLES;
                end
            end
            v = pick_value();
            send_value(v);
            // 0 and 1 are taken without any output; they don't count
            if (v >= 2)
                sent++;
        end
        in_ch.valid <= 1'b0;

        // Drain: every predicted factor must come out, then a quiet stretch
        // to catch anything extra.
        wait (outstanding == 0);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (mismatches == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
